// File: rtl/multidim_bin_range_lookup_macros.svh
// Assertion macros shared by the RTL.
`ifndef MULTIDIM_BIN_RANGE_LOOKUP_MACROS_SVH
`define MULTIDIM_BIN_RANGE_LOOKUP_MACROS_SVH

// Same-cycle implication.
`define MBRL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define MBRL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/mbrl_pkg.sv
package mbrl_pkg;

  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_NBR    = 2'd2;

  localparam logic [1:0] REG_ACTIVE_VARS     = 2'd0;
  localparam logic [1:0] REG_ACTIVE_ENTRIES  = 2'd1;
  localparam logic [1:0] REG_MATCH_TOLERANCE = 2'd2;

  localparam int NUM_COORDS = 4;

  // Control for the shared compare unit.
  typedef struct packed {
    logic nbr;     // 1: tolerance match, 0: half-open range test
    logic use_hi;  // tolerance match takes the upper edge of the candidate
  } cmp_ctrl_t;

endpackage

// File: rtl/multidim_bin_range_lookup.sv
// Bin table with range lookup and neighbor search.
// Command channel (cmd_valid/cmd_stall) carries one item: a bound write, a
// lookup over the coordinates, or a neighbor search. Each item gives exactly
// one result on the result channel (res_valid/res_stall); a transfer happens
// when valid is high and stall is low.
// The edges sit in two single-port-read RAMs of MAX_ENTRIES*MAX_VARS words.
// One edge pair is read per cycle and checked by a single compare unit: a
// lookup scans the ne loaded entries over the nv variables in use, and a
// neighbor search first reads the nv reference edges and then scans; the
// scan stops at the first match. A write or a rejected request skips the scan.
// cmd_stall is high while an item is in work; the result register lets the
// next item be taken while a result still waits. A finished item waits for
// that register while res_stall holds it full.
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once and
// must come only while the block is idle.
// Reset (rst, synchronous) restores the register defaults and empties the
// result register; the edge RAMs are not cleared and must be written first.
`include "multidim_bin_range_lookup_macros.svh"

module multidim_bin_range_lookup import mbrl_pkg::*; #(
  parameter int MAX_ENTRIES = 64,
  parameter int MAX_VARS    = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [1:0]         action,
  input  logic [5:0]         entry,
  input  logic [1:0]         var_sel,
  input  logic signed [31:0] lower_bound,
  input  logic signed [31:0] upper_bound,
  input  logic signed [31:0] coord0,
  input  logic signed [31:0] coord1,
  input  logic signed [31:0] coord2,
  input  logic signed [31:0] coord3,
  input  logic               toward_upper,
  output logic               res_valid,
  input  logic               res_stall,
  output logic               found,
  output logic [5:0]         bin_index,
  output logic               bad_request
);

  localparam int DEPTH = MAX_ENTRIES * MAX_VARS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_REF  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [2:0]  active_vars;
  logic [6:0]  active_entries;
  logic [15:0] match_tolerance;

  logic [2:0] nv;
  logic [6:0] ne;

  logic [1:0] state;
  logic       is_nbr;
  logic       up;
  logic [1:0] var_q;
  logic [5:0] ref_e;
  logic signed [31:0] x_q [NUM_COORDS];
  logic signed [31:0] ref_edge [NUM_COORDS];

  logic [6:0] iss_e;
  logic [1:0] iss_j;
  logic       iss_done;
  logic       issuing;
  logic       iss_last_j;
  logic       iss_last_e;

  logic       rd_vld;
  logic       rd_ref;
  logic [1:0] rd_j;
  logic [6:0] rd_e;
  logic       rd_last_j;
  logic       rd_last_e;
  logic       all_ok;

  logic       res_found;
  logic [5:0] res_idx;
  logic       res_bad;

  logic          cmd_take;
  logic          wr_oob;
  logic          nbr_bad;
  logic          ram_we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [31:0]   lo_rd;
  logic [31:0]   hi_rd;

  cmp_ctrl_t          cmp_ctrl;
  logic signed [31:0] cmp_ref;
  logic               cmp_ok;
  logic               ent_ok;
  logic               scan_eval;
  logic               out_free;

  // register clamps
  always_comb begin
    if (active_vars == 3'd0) begin
      nv = 3'd1;
    end else if (32'(active_vars) > MAX_VARS) begin
      nv = 3'(MAX_VARS);
    end else begin
      nv = active_vars;
    end
    if (32'(active_entries) > MAX_ENTRIES) begin
      ne = 7'(MAX_ENTRIES);
    end else begin
      ne = active_entries;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_vars     <= 3'd1;
      active_entries  <= 7'd0;
      match_tolerance <= 16'd7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_VARS:     active_vars     <= cfg_data[2:0];
        REG_ACTIVE_ENTRIES:  active_entries  <= cfg_data[6:0];
        REG_MATCH_TOLERANCE: match_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cmd_stall = (state != S_IDLE);
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign wr_oob    = (32'(entry) >= MAX_ENTRIES) || (32'(var_sel) >= MAX_VARS);
  assign nbr_bad   = ({1'b0, var_sel} >= nv) || ({1'b0, entry} >= ne);
  assign ram_we    = cmd_take && (action == ACT_WRITE) && !wr_oob;
  assign waddr     = AW'(32'(entry) * MAX_VARS + 32'(var_sel));

  assign issuing    = ((state == S_REF) || (state == S_SCAN)) && !iss_done;
  assign iss_last_j = ({1'b0, iss_j} == nv - 3'd1);
  assign iss_last_e = (iss_e == ne - 7'd1);
  always_comb begin
    if (state == S_REF) begin
      raddr = AW'(32'(ref_e) * MAX_VARS + 32'(iss_j));
    end else begin
      raddr = AW'(32'(iss_e) * MAX_VARS + 32'(iss_j));
    end
  end

  mbrl_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_lo_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (lower_bound),
    .raddr (raddr),
    .rdata (lo_rd)
  );

  mbrl_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_hi_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (upper_bound),
    .raddr (raddr),
    .rdata (hi_rd)
  );

  // along the direction variable a downward search matches the upper edge
  always_comb begin
    cmp_ctrl.nbr    = is_nbr;
    cmp_ctrl.use_hi = is_nbr && (rd_j == var_q) && !up;
    cmp_ref         = is_nbr ? ref_edge[rd_j] : x_q[rd_j];
  end

  mbrl_cmp u_cmp (
    .ctrl    (cmp_ctrl),
    .lo      (lo_rd),
    .hi      (hi_rd),
    .ref_val (cmp_ref),
    .tol     (match_tolerance),
    .ok      (cmp_ok)
  );

  assign ent_ok    = all_ok && cmp_ok;
  assign scan_eval = rd_vld && !rd_ref && (state == S_SCAN);
  assign out_free  = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      iss_done <= 1'b0;
      rd_vld   <= 1'b0;
    end else begin
      rd_vld <= issuing;
      unique case (state)
        S_IDLE: begin
          if (cmd_take) begin
            iss_e    <= 7'd0;
            iss_j    <= 2'd0;
            iss_done <= 1'b0;
            all_ok   <= 1'b1;
            is_nbr   <= (action == ACT_NBR);
            up       <= toward_upper;
            var_q    <= var_sel;
            ref_e    <= entry;
            x_q[0]   <= coord0;
            x_q[1]   <= coord1;
            x_q[2]   <= coord2;
            x_q[3]   <= coord3;
            res_found <= 1'b0;
            res_idx   <= 6'd0;
            res_bad   <= 1'b0;
            unique case (action)
              ACT_WRITE: begin
                res_bad <= wr_oob;
                state   <= S_FIN;
              end
              ACT_LOOKUP: begin
                state <= (ne == 7'd0) ? S_FIN : S_SCAN;
              end
              ACT_NBR: begin
                res_bad <= nbr_bad;
                state   <= nbr_bad ? S_FIN : S_REF;
              end
              default: begin
                res_bad <= 1'b1;
                state   <= S_FIN;
              end
            endcase
          end
        end
        S_REF: begin
          if (iss_last_j) begin
            iss_j <= 2'd0;
            state <= S_SCAN;
          end else begin
            iss_j <= iss_j + 2'd1;
          end
        end
        S_SCAN: begin
          if (issuing) begin
            if (iss_last_j) begin
              iss_j <= 2'd0;
              iss_e <= iss_e + 7'd1;
              if (iss_last_e) begin
                iss_done <= 1'b1;
              end
            end else begin
              iss_j <= iss_j + 2'd1;
            end
          end
          if (scan_eval) begin
            if (rd_last_j) begin
              all_ok <= 1'b1;
              if (ent_ok) begin
                res_found <= 1'b1;
                res_idx   <= rd_e[5:0];
                iss_done  <= 1'b1;
                state     <= S_FIN;
              end else if (rd_last_e) begin
                state <= S_FIN;
              end
            end else begin
              all_ok <= ent_ok;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // read tags follow the RAM latency
  always_ff @(posedge clk) begin
    rd_ref    <= (state == S_REF);
    rd_j      <= iss_j;
    rd_e      <= iss_e;
    rd_last_j <= iss_last_j;
    rd_last_e <= iss_last_e;
    if (rd_vld && rd_ref) begin
      ref_edge[rd_j] <= ((rd_j == var_q) && up) ? hi_rd : lo_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == S_FIN) && out_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && out_free) begin
      found       <= res_found;
      bin_index   <= res_idx;
      bad_request <= res_bad;
    end
  end

  `MBRL_ASSERT_NEXT(a_take_busy, clk, rst, cmd_take, state != S_IDLE)
  `MBRL_ASSERT_NOW(a_found_clean, clk, rst, res_valid, !(found && bad_request))
  `MBRL_ASSERT_NOW(a_miss_zero, clk, rst, res_valid && !found, bin_index == 6'd0)
  `MBRL_ASSERT_NOW(a_scan_var, clk, rst, scan_eval, {1'b0, rd_j} < nv)

endmodule

// File: rtl/mbrl_ram.sv
module mbrl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/mbrl_cmp.sv
module mbrl_cmp import mbrl_pkg::*; (
  input  cmp_ctrl_t          ctrl,
  input  logic signed [31:0] lo,
  input  logic signed [31:0] hi,
  input  logic signed [31:0] ref_val,
  input  logic [15:0]        tol,
  output logic               ok
);

  logic signed [31:0] cand;
  logic [32:0]        diff;
  logic [32:0]        mag;

  always_comb begin
    cand = ctrl.use_hi ? hi : lo;
    // exact difference at 33 bits, then magnitude
    diff = {cand[31], cand} - {ref_val[31], ref_val};
    mag  = diff[32] ? (~diff + 33'd1) : diff;
    if (ctrl.nbr) begin
      ok = (mag < {17'd0, tol});
    end else begin
      ok = (ref_val >= lo) && (ref_val < hi);
    end
  end

endmodule
